// ===== design/pic_pkg.sv =====
// shared types, codes and constants of the priority interrupt controller
// no dependencies; used by pic_level_cell and priority_interrupt_controller
`default_nettype none

package pic_pkg;

    localparam int NUM_LEVELS         = 8;
    localparam int LVL_W              = 3;
    localparam int MAX_RESPONSE_BYTES = 4;
    localparam int LEN_W              = 3;
    localparam int WIDX_W             = 3;

    // item kinds
    typedef enum logic [2:0] {
        FUNC_LINE   = 3'd0,
        FUNC_CMD    = 3'd1,
        FUNC_DATA   = 3'd2,
        FUNC_STATUS = 3'd3,
        FUNC_READ   = 3'd4,
        FUNC_ACK    = 3'd5
    } func_t;

    // command groups, command byte bits 7:3
    localparam logic [4:0] CMD_RESET       = 5'd0;
    localparam logic [4:0] CMD_CLR_RM_ALL  = 5'd2;
    localparam logic [4:0] CMD_CLR_RM_SEL  = 5'd3;
    localparam logic [4:0] CMD_UNMASK_ALL  = 5'd4;
    localparam logic [4:0] CMD_UNMASK_SEL  = 5'd5;
    localparam logic [4:0] CMD_MASK_ALL    = 5'd6;
    localparam logic [4:0] CMD_MASK_SEL    = 5'd7;
    localparam logic [4:0] CMD_REQ_CLR_ALL = 5'd8;
    localparam logic [4:0] CMD_REQ_CLR_SEL = 5'd9;
    localparam logic [4:0] CMD_REQ_SET_ALL = 5'd10;
    localparam logic [4:0] CMD_REQ_SET_SEL = 5'd11;
    localparam logic [4:0] CMD_ISR_CLR_HI0 = 5'd12;
    localparam logic [4:0] CMD_ISR_CLR_HI1 = 5'd13;
    localparam logic [4:0] CMD_ISR_CLR_ALL = 5'd14;
    localparam logic [4:0] CMD_ISR_CLR_SEL = 5'd15;
    localparam logic [4:0] CMD_MODE_LO0    = 5'd16;
    localparam logic [4:0] CMD_MODE_LO1    = 5'd17;
    localparam logic [4:0] CMD_MODE_LO2    = 5'd18;
    localparam logic [4:0] CMD_MODE_LO3    = 5'd19;
    localparam logic [4:0] CMD_MODE_HI0    = 5'd20;
    localparam logic [4:0] CMD_MODE_HI1    = 5'd21;
    localparam logic [4:0] CMD_RESP_LEN0   = 5'd28;
    localparam logic [4:0] CMD_RESP_LEN1   = 5'd29;
    localparam logic [4:0] CMD_RESP_LEN2   = 5'd30;
    localparam logic [4:0] CMD_RESP_LEN3   = 5'd31;

    // data write targets, last command bits 7:4
    localparam logic [3:0] DCMD_MASK  = 4'hb;
    localparam logic [3:0] DCMD_ACR   = 4'hc;
    localparam logic [3:0] DCMD_RESP0 = 4'he;
    localparam logic [3:0] DCMD_RESP1 = 4'hf;

    // enable sub-command, command byte bits 1:0
    localparam logic [1:0] ENA_SET = 2'd1;
    localparam logic [1:0] ENA_CLR = 2'd2;

    // mode register bits and fields
    localparam int MODE_EN   = 7;
    localparam int MODE_POL  = 4;
    localparam int MODE_POLL = 2;
    localparam int MODE_VEC  = 1;
    localparam int MODE_AUTO = 0;
    localparam logic [7:0] MODE_KEEP_LO  = 8'he0;
    localparam logic [7:0] MODE_LO_FIELD = 8'h1f;
    localparam logic [7:0] MODE_KEEP_SEL = 8'h9f;
    localparam logic [7:0] MODE_SEL_FIELD = 8'h60;

    localparam logic [7:0] STAT_FOUND = 8'h80;

    // register read select, mode bits 6:5
    localparam logic [1:0] RSEL_ISR  = 2'd0;
    localparam logic [1:0] RSEL_MASK = 2'd1;
    localparam logic [1:0] RSEL_REQ  = 2'd2;

    // operation broadcast to the level cells
    typedef enum logic [4:0] {
        OP_NONE,
        OP_RESET,
        OP_LINE,
        OP_CLR_RM_ALL,
        OP_CLR_RM_SEL,
        OP_MASK_CLR_ALL,
        OP_MASK_CLR_SEL,
        OP_MASK_SET_ALL,
        OP_MASK_SET_SEL,
        OP_REQ_CLR_ALL,
        OP_REQ_CLR_SEL,
        OP_REQ_SET_ALL,
        OP_REQ_SET_SEL,
        OP_ISR_CLR_ALL,
        OP_ISR_CLR_SEL,
        OP_SET_LEN,
        OP_MASK_LOAD,
        OP_ACR_LOAD,
        OP_RESP_WR,
        OP_ACK
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic                  line_active;
        logic [LEN_W-1:0]      len;
        logic [WIDX_W-1:0]     widx;
        logic [7:0]            data;
    } cell_ctl_t;

    // priority scan keys: pending, in service, either
    typedef struct packed {
        logic pend;
        logic isr;
        logic hit;
    } scan_t;

    typedef struct packed {
        logic             req;
        logic             isr;
        logic             mask;
        logic             acr;
        logic [LEN_W-1:0] len;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== design/pic_level_cell.sv =====
// one interrupt level: request, in-service, mask, auto-clear, line state
// and response bytes, plus its link of the priority scan chain; uses pic_pkg
`default_nettype none

module pic_level_cell #(
    parameter int MAX_BYTES = pic_pkg::MAX_RESPONSE_BYTES
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire pic_pkg::cell_ctl_t      ctl,
    input  wire logic                    sel,
    input  wire logic                    data_bit,
    input  wire logic                    upper,
    input  wire pic_pkg::scan_t          hi_in,
    input  wire pic_pkg::scan_t          lo_in,
    input  wire pic_pkg::scan_t          any_hi,
    output pic_pkg::scan_t               hi_out,
    output pic_pkg::scan_t               lo_out,
    output pic_pkg::scan_t               claim,
    output pic_pkg::cell_stat_t          stat,
    output logic [MAX_BYTES*8-1:0]       resp_bytes
);
    import pic_pkg::*;

    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    logic             req_reg, req_next;
    logic             isr_reg, isr_next;
    logic             mask_reg, mask_next;
    logic             acr_reg, acr_next;
    logic             line_reg, line_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       bytes_reg [MAX_BYTES];
    logic [7:0]       bytes_next [MAX_BYTES];
    scan_t            key;

    always_comb begin
        req_next  = req_reg;
        isr_next  = isr_reg;
        mask_next = mask_reg;
        acr_next  = acr_reg;
        line_next = line_reg;
        len_next  = len_reg;
        for (int j = 0; j < MAX_BYTES; j++) begin
            bytes_next[j] = bytes_reg[j];
        end
        case (ctl.op)
            OP_RESET: begin
                req_next  = 1'b0;
                isr_next  = 1'b0;
                mask_next = 1'b1;
                acr_next  = 1'b0;
                line_next = 1'b0;
                len_next  = '0;
                for (int j = 0; j < MAX_BYTES; j++) begin
                    bytes_next[j] = '0;
                end
            end
            OP_LINE: begin
                if (sel) begin
                    if (ctl.line_active) begin
                        if (!line_reg) begin
                            req_next = 1'b1;
                        end
                        line_next = 1'b1;
                    end else begin
                        line_next = 1'b0;
                        req_next  = 1'b0;
                    end
                end
            end
            OP_CLR_RM_ALL: begin
                req_next  = 1'b0;
                mask_next = 1'b0;
            end
            OP_CLR_RM_SEL: begin
                if (sel) begin
                    req_next  = 1'b0;
                    mask_next = 1'b0;
                end
            end
            OP_MASK_CLR_ALL: mask_next = 1'b0;
            OP_MASK_CLR_SEL: if (sel) mask_next = 1'b0;
            OP_MASK_SET_ALL: mask_next = 1'b1;
            OP_MASK_SET_SEL: if (sel) mask_next = 1'b1;
            OP_REQ_CLR_ALL:  req_next = 1'b0;
            OP_REQ_CLR_SEL:  if (sel) req_next = 1'b0;
            OP_REQ_SET_ALL:  req_next = 1'b1;
            OP_REQ_SET_SEL:  if (sel) req_next = 1'b1;
            OP_ISR_CLR_ALL:  isr_next = 1'b0;
            OP_ISR_CLR_SEL:  if (sel) isr_next = 1'b0;
            OP_SET_LEN:      if (sel) len_next = ctl.len;
            OP_MASK_LOAD:    mask_next = data_bit;
            OP_ACR_LOAD:     acr_next = data_bit;
            OP_RESP_WR: begin
                if (sel) begin
                    bytes_next[ctl.widx[IDX_W-1:0]] = ctl.data;
                end
            end
            OP_ACK: begin
                if (sel) begin
                    if (!acr_reg) begin
                        isr_next = 1'b1;
                    end
                    req_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg  <= 1'b0;
            isr_reg  <= 1'b0;
            mask_reg <= 1'b1;
            acr_reg  <= 1'b0;
            line_reg <= 1'b0;
            len_reg  <= '0;
            for (int j = 0; j < MAX_BYTES; j++) begin
                bytes_reg[j] <= '0;
            end
        end else begin
            req_reg  <= req_next;
            isr_reg  <= isr_next;
            mask_reg <= mask_next;
            acr_reg  <= acr_next;
            line_reg <= line_next;
            len_reg  <= len_next;
            for (int j = 0; j < MAX_BYTES; j++) begin
                bytes_reg[j] <= bytes_next[j];
            end
        end
    end

    // scan chain link: upper half (at or above base) and wrapped half
    assign key.pend = req_reg & ~mask_reg;
    assign key.isr  = isr_reg;
    assign key.hit  = isr_reg | key.pend;

    assign hi_out = hi_in | (key & {3{upper}});
    assign lo_out = lo_in | (key & {3{~upper}});
    assign claim  = (key & {3{upper}} & ~hi_in)
                  | (key & {3{~upper}} & ~lo_in & ~any_hi);

    assign stat.req  = req_reg;
    assign stat.isr  = isr_reg;
    assign stat.mask = mask_reg;
    assign stat.acr  = acr_reg;
    assign stat.len  = len_reg;

    always_comb begin
        for (int j = 0; j < MAX_BYTES; j++) begin
            resp_bytes[j*8 +: 8] = bytes_reg[j];
        end
    end

endmodule

`default_nettype wire

// ===== design/priority_interrupt_controller.sv =====
// eight-level priority interrupt controller, top level; uses pic_pkg and pic_level_cell
// an accepted item updates the level state and fills the evaluation stage, then the interrupt is
// re-evaluated into the output register; throughput one item per cycle while the output is not stalled,
// limited by the combinational scan along the chain of eight level cells
// reset: synchronous active-low aresetn clears all levels, masks all ones, no pending output
`default_nettype none

module priority_interrupt_controller #(
    parameter int MAX_RESPONSE_BYTES = pic_pkg::MAX_RESPONSE_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: priority_base
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // func[2:0], line_index[5:3], line_level[6], bus_data[14:7], zero[15]
    input  wire logic [15:0] s_tdata,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // int_request[0], read_data[8:1], vector_response[40:9], ack_found[41], zero[47:42]
    output logic [47:0]      m_tdata
);
    import pic_pkg::*;

    // ------------------------------------------------------------------
    // input fields
    // ------------------------------------------------------------------
    func_t       in_func;
    logic [2:0]  in_line;
    logic        in_level;
    logic [7:0]  in_data;

    assign in_func  = func_t'(s_tdata[2:0]);
    assign in_line  = s_tdata[5:3];
    assign in_level = s_tdata[6];
    assign in_data  = s_tdata[14:7];

    // ------------------------------------------------------------------
    // global registers
    // ------------------------------------------------------------------
    logic [LVL_W-1:0]  base_reg, base_next;
    logic [7:0]        mode_reg, mode_next;
    logic [7:0]        last_cmd_reg, last_cmd_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic              int_line_reg, int_next;

    // two-entry output path: evaluation stage then output register
    logic              p1_valid_reg;
    logic [7:0]        p1_rd_reg;
    logic [31:0]       p1_vec_reg;
    logic              p1_found_reg;
    logic              m_valid_reg;
    logic              m_int_reg;
    logic [7:0]        m_rd_reg;
    logic [31:0]       m_vec_reg;
    logic              m_found_reg;

    logic              p1_adv;
    logic              s_fire;

    // ------------------------------------------------------------------
    // level cell row with its two scan chains
    // ------------------------------------------------------------------
    cell_ctl_t                      ctl;
    logic [NUM_LEVELS-1:0]          sel_vec;
    scan_t                          hi_chain [NUM_LEVELS+1];
    scan_t                          lo_chain [NUM_LEVELS+1];
    scan_t                          claim [NUM_LEVELS];
    cell_stat_t                     stat [NUM_LEVELS];
    logic [MAX_RESPONSE_BYTES*8-1:0] cell_bytes [NUM_LEVELS];

    logic [NUM_LEVELS-1:0] req_vec, isr_vec, mask_vec, acr_vec;
    logic [NUM_LEVELS-1:0] pend_claim, isr_claim, hit_claim;

    assign hi_chain[0] = '0;
    assign lo_chain[0] = '0;

    for (genvar gi = 0; gi < NUM_LEVELS; gi++) begin : g_cell
        pic_level_cell #(
            .MAX_BYTES (MAX_RESPONSE_BYTES)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .sel        (sel_vec[gi]),
            .data_bit   (in_data[gi]),
            .upper      (LVL_W'(gi) >= base_reg),
            .hi_in      (hi_chain[gi]),
            .lo_in      (lo_chain[gi]),
            .any_hi     (hi_chain[NUM_LEVELS]),
            .hi_out     (hi_chain[gi+1]),
            .lo_out     (lo_chain[gi+1]),
            .claim      (claim[gi]),
            .stat       (stat[gi]),
            .resp_bytes (cell_bytes[gi])
        );

        assign req_vec[gi]    = stat[gi].req;
        assign isr_vec[gi]    = stat[gi].isr;
        assign mask_vec[gi]   = stat[gi].mask;
        assign acr_vec[gi]    = stat[gi].acr;
        assign pend_claim[gi] = claim[gi].pend;
        assign isr_claim[gi]  = claim[gi].isr;
        assign hit_claim[gi]  = claim[gi].hit;
    end

    // ------------------------------------------------------------------
    // highest pending level and the response source: that level, or level 0 when mode VEC is set
    // ------------------------------------------------------------------
    logic                           pend_found;
    logic [LVL_W-1:0]               pend_idx;
    logic [NUM_LEVELS-1:0]          src_onehot;
    logic [LEN_W-1:0]               src_len;
    logic [MAX_RESPONSE_BYTES*8-1:0] src_bytes;
    logic [31:0]                    ack_vec;

    assign pend_found = |pend_claim;
    assign src_onehot = mode_reg[MODE_VEC] ? NUM_LEVELS'(1) : pend_claim;

    always_comb begin
        pend_idx  = '0;
        src_len   = '0;
        src_bytes = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (pend_claim[i]) begin
                pend_idx = pend_idx | LVL_W'(i);
            end
            if (src_onehot[i]) begin
                src_len   = src_len | stat[i].len;
                src_bytes = src_bytes | cell_bytes[i];
            end
        end
    end

    // first byte ends up most significant
    always_comb begin
        ack_vec = '0;
        for (int j = 0; j < MAX_RESPONSE_BYTES; j++) begin
            if (LEN_W'(j) < src_len) begin
                ack_vec = {ack_vec[23:0], src_bytes[j*8 +: 8]};
            end
        end
    end

    // ------------------------------------------------------------------
    // item decode
    // ------------------------------------------------------------------
    logic [7:0]            rd;
    logic [31:0]           vec;
    logic                  found;
    logic [NUM_LEVELS-1:0] line_dec, cmd_dec, lc_dec;
    logic [LEN_W-1:0]      len_raw;
    logic [LEN_W-1:0]      lc_len;

    assign line_dec = NUM_LEVELS'(1) << in_line;
    assign cmd_dec  = NUM_LEVELS'(1) << in_data[2:0];
    assign lc_dec   = NUM_LEVELS'(1) << last_cmd_reg[2:0];
    assign len_raw  = {1'b0, in_data[4:3]} + LEN_W'(1);

    always_comb begin
        lc_len = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (lc_dec[i]) begin
                lc_len = lc_len | stat[i].len;
            end
        end
    end

    always_comb begin
        ctl             = '0;
        ctl.op          = OP_NONE;
        ctl.data        = in_data;
        ctl.line_active = (in_level == mode_reg[MODE_POL]);
        ctl.widx        = widx_reg;
        ctl.len         = (len_raw > LEN_W'(MAX_RESPONSE_BYTES))
                        ? LEN_W'(MAX_RESPONSE_BYTES) : len_raw;
        sel_vec         = cmd_dec;
        base_next       = base_reg;
        mode_next       = mode_reg;
        last_cmd_next   = last_cmd_reg;
        widx_next       = widx_reg;
        rd              = '0;
        vec             = '0;
        found           = 1'b0;

        if (s_fire) begin
            case (in_func)
                FUNC_LINE: begin
                    ctl.op  = OP_LINE;
                    sel_vec = line_dec;
                end
                FUNC_CMD: begin
                    last_cmd_next = in_data;
                    case (in_data[7:3])
                        CMD_RESET: begin
                            ctl.op        = OP_RESET;
                            base_next     = '0;
                            mode_next     = '0;
                            last_cmd_next = '0;
                            widx_next     = '0;
                        end
                        CMD_CLR_RM_ALL:  ctl.op = OP_CLR_RM_ALL;
                        CMD_CLR_RM_SEL:  ctl.op = OP_CLR_RM_SEL;
                        CMD_UNMASK_ALL:  ctl.op = OP_MASK_CLR_ALL;
                        CMD_UNMASK_SEL:  ctl.op = OP_MASK_CLR_SEL;
                        CMD_MASK_ALL:    ctl.op = OP_MASK_SET_ALL;
                        CMD_MASK_SEL:    ctl.op = OP_MASK_SET_SEL;
                        CMD_REQ_CLR_ALL: ctl.op = OP_REQ_CLR_ALL;
                        CMD_REQ_CLR_SEL: ctl.op = OP_REQ_CLR_SEL;
                        CMD_REQ_SET_ALL: ctl.op = OP_REQ_SET_ALL;
                        CMD_REQ_SET_SEL: ctl.op = OP_REQ_SET_SEL;
                        CMD_ISR_CLR_HI0, CMD_ISR_CLR_HI1: begin
                            // only the first in-service level in priority order
                            ctl.op  = OP_ISR_CLR_SEL;
                            sel_vec = isr_claim;
                        end
                        CMD_ISR_CLR_ALL: ctl.op = OP_ISR_CLR_ALL;
                        CMD_ISR_CLR_SEL: ctl.op = OP_ISR_CLR_SEL;
                        CMD_MODE_LO0, CMD_MODE_LO1, CMD_MODE_LO2, CMD_MODE_LO3: begin
                            mode_next = (mode_reg & MODE_KEEP_LO) | (in_data & MODE_LO_FIELD);
                        end
                        CMD_MODE_HI0, CMD_MODE_HI1: begin
                            mode_next = (mode_reg & MODE_KEEP_SEL) | (in_data & MODE_SEL_FIELD);
                            if (in_data[1:0] == ENA_SET) begin
                                mode_next[MODE_EN] = 1'b1;
                            end else if (in_data[1:0] == ENA_CLR) begin
                                mode_next[MODE_EN] = 1'b0;
                            end
                        end
                        CMD_RESP_LEN0, CMD_RESP_LEN1, CMD_RESP_LEN2, CMD_RESP_LEN3: begin
                            ctl.op    = OP_SET_LEN;
                            widx_next = '0;
                        end
                        default: ;
                    endcase
                end
                FUNC_DATA: begin
                    // targets below the mask load leave last command untouched
                    if (last_cmd_reg[7:4] >= DCMD_MASK) begin
                        last_cmd_next = '0;
                        case (last_cmd_reg[7:4])
                            DCMD_MASK: ctl.op = OP_MASK_LOAD;
                            DCMD_ACR:  ctl.op = OP_ACR_LOAD;
                            DCMD_RESP0, DCMD_RESP1: begin
                                if (widx_reg < lc_len &&
                                    widx_reg < WIDX_W'(MAX_RESPONSE_BYTES)) begin
                                    ctl.op        = OP_RESP_WR;
                                    sel_vec       = lc_dec;
                                    widx_next     = widx_reg + WIDX_W'(1);
                                    last_cmd_next = last_cmd_reg;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                FUNC_STATUS: begin
                    if (pend_found) begin
                        rd = STAT_FOUND | {5'd0, pend_idx};
                    end
                    rd[3] = mode_reg[MODE_EN];
                    rd[4] = mode_reg[MODE_POLL];
                    rd[5] = mode_reg[MODE_AUTO];
                end
                FUNC_READ: begin
                    case (mode_reg[6:5])
                        RSEL_ISR:  rd = isr_vec;
                        RSEL_MASK: rd = mask_vec;
                        RSEL_REQ:  rd = req_vec;
                        default:   rd = acr_vec;
                    endcase
                end
                FUNC_ACK: begin
                    if (pend_found) begin
                        ctl.op  = OP_ACK;
                        sel_vec = pend_claim;
                        vec     = ack_vec;
                        found   = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // to be written only while idle: a rule for the user, unchecked by the block
        if (cfg_wr_en) begin
            base_next = cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // interrupt output, evaluated on the state the item left behind
    // ------------------------------------------------------------------
    logic int_hit;

    // first pending-or-in-service level is pending and not in service
    assign int_hit = |(hit_claim & ~isr_vec);

    always_comb begin
        if (!mode_reg[MODE_EN]) begin
            int_next = int_line_reg;
        end else if (int_hit) begin
            int_next = mode_reg[MODE_POLL] ? int_line_reg : 1'b1;
        end else begin
            int_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // handshake and registers
    // ------------------------------------------------------------------
    assign p1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || p1_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            mode_reg     <= '0;
            last_cmd_reg <= '0;
            widx_reg     <= '0;
            int_line_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            base_reg     <= base_next;
            mode_reg     <= mode_next;
            last_cmd_reg <= last_cmd_next;
            widx_reg     <= widx_next;
            p1_valid_reg <= s_fire || (p1_valid_reg && !p1_adv);
            if (p1_adv) begin
                m_valid_reg <= p1_valid_reg;
            end
            if (p1_valid_reg && p1_adv) begin
                int_line_reg <= int_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_rd_reg    <= rd;
            p1_vec_reg   <= vec;
            p1_found_reg <= found;
        end
        if (p1_valid_reg && p1_adv) begin
            m_int_reg   <= int_next;
            m_rd_reg    <= p1_rd_reg;
            m_vec_reg   <= p1_vec_reg;
            m_found_reg <= p1_found_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_found_reg, m_vec_reg, m_rd_reg, m_int_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pend_claim_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pend_claim))
        else $error("more than one pending level claimed");

    a_isr_claim_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(isr_claim))
        else $error("more than one in-service level claimed");

    a_reset_cmd_masks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_func == FUNC_CMD && in_data[7:3] == CMD_RESET)
        |=> (mask_vec == '1 && req_vec == '0 && isr_vec == '0))
        else $error("reset command did not restore level state");

    a_ack_clears_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_func == FUNC_ACK && pend_found)
        |=> ((req_vec & $past(pend_claim)) == '0))
        else $error("acknowledged level still requesting");

endmodule

`default_nettype wire
